// ===== hdl/bhp_pkg.sv =====
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared types, constants and helpers of the BMP header stream parser.
// ----------------------------------------------------------------------------
package bhp_pkg;

  localparam logic [7:0]  SIG_B0   = 8'h42;
  localparam logic [7:0]  SIG_B1   = 8'h4D;
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] PLANES_1 = 16'd1;
  localparam logic [31:0] HDR_END  = 32'd38;
  localparam logic [31:0] HDR_LAST = 32'd37;
  localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF;

  // Largest pixel count whose byte size still fits in 32 bits.
  localparam logic [31:0] MAX_PIX_COUNT = 32'(64'hFFFF_FFFF / 64'd3);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIG  = 3'd1;
  localparam logic [2:0] ST_SIZE_MIS = 3'd2;
  localparam logic [2:0] ST_PLANES   = 3'd3;
  localparam logic [2:0] ST_DEPTH    = 3'd4;
  localparam logic [2:0] ST_COMPRESS = 3'd5;
  localparam logic [2:0] ST_SHORT    = 3'd6;
  localparam logic [2:0] ST_OVERFLOW = 3'd7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_byte;
    logic        pixel_valid;
    logic        pixel_last;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        top_down;
    logic [31:0] image_bytes;
  } result_t;

  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height_raw;
  } dims_t;

  typedef struct packed {
    logic        overflow;
    logic [31:0] byte_count;
  } size_info_t;

  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [7:0]  b,
                                           input logic [1:0]  lane);
    put_byte = word | (32'(b) << {lane, 3'b000});
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] raw);
    magnitude = raw[31] ? (~raw + 32'd1) : raw;
  endfunction

endpackage

// ===== hdl/bhp_if.sv =====
// ----------------------------------------------------------------------------
// bhp_in_if / bhp_out_if
// Valid/ready channels for the file byte stream and the parser results.
// ----------------------------------------------------------------------------
interface bhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_end;

  modport source (output valid, output in_byte, output file_end, input ready);
  modport sink   (input valid, input in_byte, input file_end, output ready);
endinterface

interface bhp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_byte;
  logic        pixel_valid;
  logic        pixel_last;
  logic        done_res;
  logic [2:0]  status;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic        top_down;
  logic [31:0] image_bytes;

  modport source (output valid, output pixel_byte, output pixel_valid, output pixel_last,
                  output done_res, output status, output image_width, output image_height,
                  output top_down, output image_bytes, input ready);
  modport sink   (input valid, input pixel_byte, input pixel_valid, input pixel_last,
                  input done_res, input status, input image_width, input image_height,
                  input top_down, input image_bytes, output ready);
endinterface

// ===== hdl/bmp_header_stream_parser.sv =====
// ----------------------------------------------------------------------------
// bmp_header_stream_parser
// Streaming parser for uncompressed 24-bit BMP files.
// ----------------------------------------------------------------------------
// The parser takes one file byte per request and can accept a new byte in
// every clock cycle while the output is not held off; a byte passes an
// input register and then a result register before its result is shown.
// Header fields are assembled as they pass, pixel bytes from the data
// offset onward are forwarded with the last one marked, and the byte flagged
// as the end of the file carries the status and header values. The byte
// count, width times height magnitude times three, for headers that leave
// the image size at zero comes from a three-stage multiplier that settles
// while the remaining header bytes arrive, so it never holds up a byte.
module bmp_header_stream_parser
  import bhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bhp_in_if.sink     in_stream,
  bhp_out_if.source  out_stream
);

  logic       s1_v_r;
  in_item_t   s1_item_r;
  logic       out_v_r;
  result_t    out_res_r;

  logic       s1_go;
  logic       out_free;
  logic       has_res;
  result_t    res;
  dims_t      dims;
  size_info_t size;

  assign out_free        = !out_v_r || out_stream.ready;
  assign s1_go           = s1_v_r && out_free;
  assign in_stream.ready = !s1_v_r || s1_go;

  bhp_hdr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_go (s1_go),
    .item    (s1_item_r),
    .size    (size),
    .dims    (dims),
    .res     (res),
    .has_res (has_res)
  );

  bhp_size_mult u_mult (
    .clk  (clk),
    .dims (dims),
    .size (size)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_stream.ready) begin
        s1_v_r <= in_stream.valid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      s1_item_r.in_byte  <= in_stream.in_byte;
      s1_item_r.file_end <= in_stream.file_end;
    end
    if (s1_go) begin
      out_res_r <= res;
    end
  end

  assign out_stream.valid        = out_v_r;
  assign out_stream.pixel_byte   = out_res_r.pixel_byte;
  assign out_stream.pixel_valid  = out_res_r.pixel_valid;
  assign out_stream.pixel_last   = out_res_r.pixel_last;
  assign out_stream.done_res     = out_res_r.done_res;
  assign out_stream.status       = out_res_r.status;
  assign out_stream.image_width  = out_res_r.image_width;
  assign out_stream.image_height = out_res_r.image_height;
  assign out_stream.top_down     = out_res_r.top_down;
  assign out_stream.image_bytes  = out_res_r.image_bytes;

  a_res_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_res_r.pixel_valid || out_res_r.done_res))
    else $error("result carries neither a pixel byte nor a done report");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.pixel_last) |-> out_res_r.pixel_valid)
    else $error("pixel_last set on a result without a pixel byte");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_stream.ready) |-> !in_stream.ready)
    else $error("input accepted while both stages are held");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_item_r)))
    else $error("held input item lost or changed");

endmodule

// ===== hdl/bhp_size_mult.sv =====
// ----------------------------------------------------------------------------
// bhp_size_mult
// Three-stage pipeline forming width * |height| * 3 and its overflow flag.
// ----------------------------------------------------------------------------
module bhp_size_mult
  import bhp_pkg::*;
(
  input  logic       clk,
  input  dims_t      dims,
  output size_info_t size
);

  logic [31:0] hmag_r;
  logic [31:0] width_r;
  logic [63:0] prod_r;
  logic [31:0] bytes_r;
  logic        ovf_r;

  always_ff @(posedge clk) begin
    hmag_r  <= magnitude(dims.height_raw);
    width_r <= dims.width;
    prod_r  <= 64'(width_r) * 64'(hmag_r);
    bytes_r <= {prod_r[30:0], 1'b0} + prod_r[31:0];
    ovf_r   <= (|prod_r[63:32]) || (prod_r[31:0] > MAX_PIX_COUNT);
  end

  assign size.overflow   = ovf_r;
  assign size.byte_count = bytes_r;

endmodule

// ===== hdl/bhp_hdr_parse.sv =====
// ----------------------------------------------------------------------------
// bhp_hdr_parse
// Header field assembly, error tracking and pixel window decode.
// ----------------------------------------------------------------------------
module bhp_hdr_parse
  import bhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_go,
  input  in_item_t   item,
  input  size_info_t size,
  output dims_t      dims,
  output result_t    res,
  output logic       has_res
);

  logic [31:0] pos_r, pos_nxt;
  logic [32:0] len_r, len_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] total_r, total_nxt;
  logic [7:0]  scratch_r, scratch_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [31:0] p;
  logic [7:0]  b;
  logic [15:0] field16;
  logic [31:0] diff;
  logic [32:0] data_end;
  logic        pv;
  logic        pl;
  logic [2:0]  st;

  assign p = pos_r;
  assign b = item.in_byte;

  always_comb begin
    decl_nxt    = decl_r;
    off_nxt     = off_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    total_nxt   = total_r;
    scratch_nxt = scratch_r;
    err_nxt     = err_r;
    field16     = {b, scratch_r};

    priority if (p == 32'd0) begin
      if (b != SIG_B0 && err_nxt == ST_OK) err_nxt = ST_BAD_SIG;
    end else if (p == 32'd1) begin
      if (b != SIG_B1 && err_nxt == ST_OK) err_nxt = ST_BAD_SIG;
    end else if (p >= 32'd2 && p <= 32'd5) begin
      decl_nxt = put_byte(decl_r, b, p[1:0] - 2'd2);
    end else if (p >= 32'd10 && p <= 32'd13) begin
      off_nxt = put_byte(off_r, b, p[1:0] - 2'd2);
    end else if (p >= 32'd18 && p <= 32'd21) begin
      width_nxt = put_byte(width_r, b, p[1:0] - 2'd2);
    end else if (p >= 32'd22 && p <= 32'd25) begin
      height_nxt = put_byte(height_r, b, p[1:0] - 2'd2);
    end else if (p == 32'd26 || p == 32'd28) begin
      scratch_nxt = b;
    end else if (p == 32'd27 || p == 32'd29) begin
      if (p == 32'd27 && field16 != PLANES_1 && err_nxt == ST_OK) err_nxt = ST_PLANES;
      if (p == 32'd29 && field16 != DEPTH_24 && err_nxt == ST_OK) err_nxt = ST_DEPTH;
      scratch_nxt = 8'd0;
    end else if (p >= 32'd30 && p <= 32'd33) begin
      if (b != 8'd0 && err_nxt == ST_OK) err_nxt = ST_COMPRESS;
    end else if (p >= 32'd34 && p <= HDR_LAST) begin
      total_nxt = put_byte(total_r, b, p[1:0] - 2'd2);
      if (p == HDR_LAST && total_nxt == 32'd0) begin
        if (size.overflow) begin
          if (err_nxt == ST_OK) err_nxt = ST_OVERFLOW;
        end else begin
          total_nxt = size.byte_count;
        end
      end
    end else begin
    end
  end

  assign diff = p - off_r;
  assign pv   = (p >= HDR_END) && (err_r == ST_OK) && (off_r >= HDR_END) &&
                (p >= off_r) && (diff < total_r);
  assign pl   = pv && (diff == total_r - 32'd1);

  assign data_end = {1'b0, off_nxt} + {1'b0, total_nxt};

  always_comb begin
    priority if (err_nxt == ST_BAD_SIG) begin
      st = ST_BAD_SIG;
    end else if ({1'b0, decl_nxt} != len_r) begin
      st = ST_SIZE_MIS;
    end else if (err_nxt != ST_OK) begin
      st = err_nxt;
    end else if (p < HDR_LAST || off_nxt < HDR_END || data_end > len_r) begin
      st = ST_SHORT;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    res              = '0;
    res.pixel_valid  = pv;
    res.pixel_last   = pl;
    res.pixel_byte   = pv ? b : 8'd0;
    if (item.file_end) begin
      res.done_res     = 1'b1;
      res.status       = st;
      res.image_width  = width_nxt;
      res.image_height = magnitude(height_nxt);
      res.top_down     = height_nxt[31];
      res.image_bytes  = total_nxt;
    end
  end

  assign has_res = pv || item.file_end;

  assign pos_nxt = (pos_r != POS_MAX) ? pos_r + 32'd1 : pos_r;
  assign len_nxt = (pos_r != POS_MAX) ? len_r + 33'd1 : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      len_r     <= 33'd1;
      decl_r    <= '0;
      off_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      total_r   <= '0;
      scratch_r <= '0;
      err_r     <= ST_OK;
    end else if (item_go) begin
      if (item.file_end) begin
        pos_r     <= '0;
        len_r     <= 33'd1;
        decl_r    <= '0;
        off_r     <= '0;
        width_r   <= '0;
        height_r  <= '0;
        total_r   <= '0;
        scratch_r <= '0;
        err_r     <= ST_OK;
      end else begin
        pos_r     <= pos_nxt;
        len_r     <= len_nxt;
        decl_r    <= decl_nxt;
        off_r     <= off_nxt;
        width_r   <= width_nxt;
        height_r  <= height_nxt;
        total_r   <= total_nxt;
        scratch_r <= scratch_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  assign dims.width      = width_r;
  assign dims.height_raw = height_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bmp_header_stream_parser.
// A short table of hand-made byte sequences comes first. After it come whole
// BMP files, both well-formed and broken, with random content, fed one byte
// per request. Reports that end a table sequence are checked against the
// table; every other result is compared with a model in step with the block.
// ----------------------------------------------------------------------------
module testbench;
  import bhp_pkg::*;

  localparam int HOLD_CYCLES = 100;
  localparam int DIR_N       = 24;

  typedef enum int {
    F_GOOD, F_GOOD_SIZED, F_BAD_SIG, F_SIZE_MIS, F_PLANES, F_DEPTH, F_COMPRESS,
    F_BAD_OFFSET, F_SHORT, F_OVERFLOW, F_PAST_END, F_MIN_HEIGHT, F_NOISE
  } file_kind_t;

  typedef struct packed {
    logic [7:0] b;
    logic       is_last;
    logic       typed;
    logic [2:0] st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bhp_in_if  in_if ();
  bhp_out_if out_if ();

  bmp_header_stream_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state.
  logic [31:0] pos;
  logic [31:0] decl_size;
  logic [31:0] data_off;
  logic [31:0] width_q;
  logic [31:0] height_q;
  logic [31:0] img_bytes;
  logic [15:0] scratch16;
  logic [2:0]  err_code;

  result_t    parsed_q[$];
  logic [7:0] file_bytes[$];
  result_t    seen_res;
  result_t    want_res;
  int         fail_count = 0;
  int         sent_items = 0;
  int         idle_pct = 0;
  bit         hold_off_req = 1'b0;

  dir_row_t dir_rows [DIR_N] = '{
    '{8'h00, 1'b1, 1'b1, ST_BAD_SIG},
    '{8'hFF, 1'b1, 1'b1, ST_BAD_SIG},
    '{8'h42, 1'b0, 1'b0, ST_OK},
    '{8'h4D, 1'b1, 1'b1, ST_SIZE_MIS},
    '{8'h42, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_BAD_SIG},
    '{8'h42, 1'b0, 1'b0, ST_OK},
    '{8'h4D, 1'b0, 1'b0, ST_OK},
    '{8'h06, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b1, ST_SHORT},
    '{8'h42, 1'b0, 1'b0, ST_OK},
    '{8'h4D, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b0, ST_OK},
    '{8'h01, 1'b0, 1'b0, ST_OK},
    '{8'h7F, 1'b0, 1'b0, ST_OK},
    '{8'hFE, 1'b0, 1'b0, ST_OK},
    '{8'hAA, 1'b0, 1'b0, ST_OK},
    '{8'h55, 1'b1, 1'b1, ST_SIZE_MIS}
  };

  task automatic parse_clear();
    pos       = '0;
    decl_size = '0;
    data_off  = '0;
    width_q   = '0;
    height_q  = '0;
    img_bytes = '0;
    scratch16 = '0;
    err_code  = ST_OK;
  endtask

  task automatic note_error(input logic [2:0] code);
    if (err_code == ST_OK) err_code = code;
  endtask

  function automatic logic [31:0] abs_height();
    return height_q[31] ? (32'd0 - height_q) : height_q;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic is_last,
                            output bit has_res, output result_t r);
    logic [31:0] p;
    logic [63:0] prod;
    logic [32:0] len;
    logic        pv;
    logic        pl;
    p = pos;
    pv = 1'b0;
    pl = 1'b0;
    r = '0;
    has_res = 1'b0;
    if (p == 0) begin
      if (b != SIG_B0) note_error(ST_BAD_SIG);
    end else if (p == 1) begin
      if (b != SIG_B1) note_error(ST_BAD_SIG);
    end else if (p >= 2 && p <= 5) begin
      decl_size = decl_size | (32'(b) << (8 * (p - 2)));
    end else if (p >= 10 && p <= 13) begin
      data_off = data_off | (32'(b) << (8 * (p - 10)));
    end else if (p >= 18 && p <= 21) begin
      width_q = width_q | (32'(b) << (8 * (p - 18)));
    end else if (p >= 22 && p <= 25) begin
      height_q = height_q | (32'(b) << (8 * (p - 22)));
    end else if (p == 26 || p == 28) begin
      scratch16 = 16'(b);
    end else if (p == 27 || p == 29) begin
      scratch16 = scratch16 | {b, 8'h00};
      if (p == 27 && scratch16 != PLANES_1) note_error(ST_PLANES);
      if (p == 29 && scratch16 != DEPTH_24) note_error(ST_DEPTH);
      scratch16 = '0;
    end else if (p >= 30 && p <= 33) begin
      if (b != 8'd0) note_error(ST_COMPRESS);
    end else if (p >= 34 && p <= HDR_LAST) begin
      img_bytes = img_bytes | (32'(b) << (8 * (p - 34)));
      if (p == HDR_LAST && img_bytes == 0) begin
        prod = 64'(width_q) * 64'(abs_height());
        if (prod > 64'(MAX_PIX_COUNT)) note_error(ST_OVERFLOW);
        else img_bytes = prod[31:0] * 32'd3;
      end
    end

    if (p >= HDR_END && err_code == ST_OK && data_off >= HDR_END &&
        p >= data_off && (p - data_off) < img_bytes) begin
      pv = 1'b1;
      pl = (p - data_off) == (img_bytes - 32'd1);
    end

    if (pv) begin
      has_res = 1'b1;
      r.pixel_byte  = b;
      r.pixel_valid = 1'b1;
      r.pixel_last  = pl;
    end
    if (is_last) begin
      has_res = 1'b1;
      len = {1'b0, p} + 33'd1;
      r.done_res = 1'b1;
      if (err_code == ST_BAD_SIG) r.status = ST_BAD_SIG;
      else if ({1'b0, decl_size} != len) r.status = ST_SIZE_MIS;
      else if (err_code != ST_OK) r.status = err_code;
      else if (p < HDR_LAST || data_off < HDR_END ||
               ({1'b0, data_off} + {1'b0, img_bytes}) > len) r.status = ST_SHORT;
      else r.status = ST_OK;
      r.image_width  = width_q;
      r.image_height = abs_height();
      r.top_down     = height_q[31];
      r.image_bytes  = img_bytes;
      parse_clear();
    end else if (pos != POS_MAX) begin
      pos = pos + 32'd1;
    end
  endtask

  // Each accepted request advances the parser model.
  task automatic send_byte(input logic [7:0] b, input logic is_last,
                           output bit has_res, output result_t r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.in_byte  <= b;
    in_if.file_end <= is_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    parse_byte(b, is_last, has_res, r);
    sent_items++;
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic build_file(input file_kind_t kind, input bit big);
    logic [31:0] w, h, hm, off, isz, pix_n, planes, depth, comp, fsize;
    int cut;
    file_bytes.delete();
    if (kind == F_NOISE) begin
      repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom));
      return;
    end
    w      = big ? $urandom_range(6, 8) : $urandom_range(1, 3);
    hm     = big ? 32'd2 : $urandom_range(1, 2);
    h      = $urandom_range(0, 1) ? (32'd0 - hm) : hm;
    pix_n  = w * hm * 32'd3;
    isz    = '0;
    off    = HDR_END + $urandom_range(0, 6);
    planes = 32'(PLANES_1);
    depth  = 32'(DEPTH_24);
    comp   = '0;
    case (kind)
      F_GOOD_SIZED: begin
        isz   = $urandom_range(1, 24);
        pix_n = isz;
        if ($urandom_range(0, 1)) begin
          w = $urandom();
          h = $urandom();
        end
      end
      F_PLANES: begin
        planes = $urandom_range(0, 1) ? 32'd0 : $urandom_range(2, 65535);
      end
      F_DEPTH: begin
        depth = $urandom_range(0, 65535);
        if (depth == 32'(DEPTH_24)) depth = 32'd32;
      end
      F_COMPRESS: begin
        comp = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : $urandom();
        if (comp == 0) comp = 32'd1;
      end
      F_BAD_OFFSET: off = $urandom_range(0, 37);
      F_OVERFLOW: begin
        hm    = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
        h     = $urandom_range(0, 1) ? (32'd0 - hm) : hm;
        w     = $urandom_range(32'h0001_0000, 32'hFFFF_FFFF);
        pix_n = 32'd4;
      end
      F_PAST_END: isz = pix_n + $urandom_range(1, 20);
      F_MIN_HEIGHT: begin
        h = 32'h8000_0000;
        if ($urandom_range(0, 1)) begin
          w     = '0;
          pix_n = '0;
        end else begin
          w   = $urandom();
          isz = pix_n;
        end
      end
      default: ;
    endcase

    file_bytes.push_back(SIG_B0);
    file_bytes.push_back(SIG_B1);
    put_le(32'd0, 4);
    put_le($urandom(), 4);
    put_le(off, 4);
    put_le(32'd40, 4);
    put_le(w, 4);
    put_le(h, 4);
    put_le(planes, 2);
    put_le(depth, 2);
    put_le(comp, 4);
    put_le(isz, 4);
    while (file_bytes.size() < off) file_bytes.push_back(8'($urandom));
    repeat (pix_n) file_bytes.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));

    if (kind == F_SHORT) begin
      cut = $urandom_range(6, 37);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    fsize = file_bytes.size();
    if (kind == F_SIZE_MIS) fsize = fsize + $urandom_range(1, 32'hFFFF_FFF0);
    for (int i = 0; i < 4; i++) file_bytes[2 + i] = fsize[8*i +: 8];
    if (kind == F_BAD_SIG) begin
      cut = $urandom_range(0, 1);
      file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
    end
  endtask

  task automatic send_file();
    bit      has_res;
    result_t r;
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1, has_res, r);
      if (has_res) parsed_q.push_back(r);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
  endtask

  task automatic show_result(input string tag, input result_t r);
    $display("  %s byte=%h pv=%b pl=%b done=%b st=%0d w=%h h=%h td=%b n=%h", tag,
             r.pixel_byte, r.pixel_valid, r.pixel_last, r.done_res, r.status,
             r.image_width, r.image_height, r.top_down, r.image_bytes);
  endtask

  initial begin
    bit         has_res;
    result_t    r;
    int         pick;
    file_kind_t kind;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = 8'd0;
    in_if.file_end = 1'b0;
    parse_clear();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 20;
    for (int i = 0; i < DIR_N; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].is_last, has_res, r);
      if (dir_rows[i].typed) begin
        r = '0;
        r.done_res = 1'b1;
        r.status   = dir_rows[i].st;
        parsed_q.push_back(r);
      end else if (has_res) begin
        parsed_q.push_back(r);
      end
    end

    for (int k = int'(F_GOOD); k <= int'(F_NOISE); k++) begin
      idle_pct = (k % 4 == 3) ? 0 : 25;
      build_file(file_kind_t'(k), 1'b0);
      send_file();
    end

    // The output is held off while a long file keeps arriving.
    idle_pct = 0;
    hold_off_req = 1'b1;
    build_file(F_GOOD, 1'b1);
    send_file();
    drain_results();

    while (sent_items < 740) begin
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      pick = $urandom_range(0, 19);
      if (pick < 7) kind = F_GOOD;
      else if (pick < 11) kind = F_GOOD_SIZED;
      else kind = file_kind_t'($urandom_range(int'(F_BAD_SIG), int'(F_NOISE)));
      build_file(kind, 1'b0);
      send_file();
    end

    idle_pct = 0;
    while (sent_items < 850) begin
      build_file($urandom_range(0, 1) ? F_GOOD : F_GOOD_SIZED, 1'b0);
      send_file();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_res = '{out_if.pixel_byte, out_if.pixel_valid, out_if.pixel_last,
                   out_if.done_res, out_if.status, out_if.image_width,
                   out_if.image_height, out_if.top_down, out_if.image_bytes};
      if (parsed_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Result with nothing expected at %0t:", $realtime);
          show_result("got", seen_res);
        end
      end else begin
        want_res = parsed_q.pop_front();
        if (want_res.pixel_byte   !== seen_res.pixel_byte   ||
            want_res.pixel_valid  !== seen_res.pixel_valid  ||
            want_res.pixel_last   !== seen_res.pixel_last   ||
            want_res.done_res     !== seen_res.done_res     ||
            want_res.status       !== seen_res.status       ||
            want_res.image_width  !== seen_res.image_width  ||
            want_res.image_height !== seen_res.image_height ||
            want_res.top_down     !== seen_res.top_down     ||
            want_res.image_bytes  !== seen_res.image_bytes) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Result mismatch at %0t:", $realtime);
            show_result("exp", want_res);
            show_result("got", seen_res);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", parsed_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bhp_pkg.sv
hdl/bhp_if.sv
hdl/bhp_size_mult.sv
hdl/bhp_hdr_parse.sv
hdl/bmp_header_stream_parser.sv
dv/testbench.sv
